// ===== hw/rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared types, constants and helpers for the 3x3 matrix inverse
// Cofactor index tables, queue entry layout and Q16.16 saturation.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned THR_W     = 56;
  localparam logic [THR_W-1:0] THR_RESET = 56'd281475;
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;

  // cofactor i = a[CX]*a[CY] - a[CU]*a[CV]
  localparam int unsigned CX [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned CY [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned CU [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned CV [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // cofactors are exact Q32.32 (65 bits), determinant exact Q48.48 (98 bits)
  typedef struct packed {
    logic [8:0][64:0] cof;
    logic [97:0]      det;
  } mi3_entry_t;

  // saturate a magnitude with a sign to signed 32 bits
  function automatic logic [31:0] sat32(input logic [65:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      if (mag > 66'h8000_0000) res = 32'h8000_0000;
      else res = 32'(~mag + 66'd1);
    end else begin
      if (mag > 66'h7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/mi3_in_if.sv =====
// ----------------------------------------------------------------------------
// mi3_in_if: matrix input channel
// Valid/ready channel carrying one 3x3 matrix of signed Q16.16 elements.
// ----------------------------------------------------------------------------
interface mi3_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                output ready);
endinterface

// ===== hw/rtl/mi3_out_if.sv =====
// ----------------------------------------------------------------------------
// mi3_out_if: inverse result channel
// Valid/ready channel carrying the inverse, the determinant and a flag.
// ----------------------------------------------------------------------------
interface mi3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [31:0] det_out;
  logic               singular;

  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  det_out, singular, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                det_out, singular, output ready);
endinterface

// ===== hw/rtl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// Five stages: products, cofactors, partial products, terms, determinant.
// ----------------------------------------------------------------------------
module mi3_front import mi3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mi3_in_if.sink     matrix,
  output logic       q_valid,
  output mi3_entry_t q_data,
  input  logic       q_ready
);

  logic signed [31:0] a [9];
  logic [5:1]         vld;
  logic               adv;

  logic signed [63:0] pxy [9];
  logic signed [63:0] puv [9];
  logic signed [31:0] a1s [3];
  logic signed [64:0] c2 [9];
  logic signed [31:0] a2s [3];
  logic signed [64:0] lo [3];
  logic signed [64:0] hi [3];
  logic signed [64:0] c3 [9];
  logic signed [97:0] t [3];
  logic signed [64:0] c4 [9];
  logic signed [97:0] det;
  logic signed [64:0] c5 [9];

  assign a[0] = matrix.a00;
  assign a[1] = matrix.a01;
  assign a[2] = matrix.a02;
  assign a[3] = matrix.a10;
  assign a[4] = matrix.a11;
  assign a[5] = matrix.a12;
  assign a[6] = matrix.a20;
  assign a[7] = matrix.a21;
  assign a[8] = matrix.a22;

  // whole pipeline holds while its last stage is valid and the queue is full
  assign adv          = !vld[5] || q_ready;
  assign matrix.ready = adv;
  assign q_valid      = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:1], matrix.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        pxy[i] <= a[CX[i]] * a[CY[i]];
        puv[i] <= a[CU[i]] * a[CV[i]];
        c2[i]  <= 65'(pxy[i]) - 65'(puv[i]);
        c3[i]  <= c2[i];
        c4[i]  <= c3[i];
        c5[i]  <= c4[i];
      end
      for (int j = 0; j < 3; j++) begin
        a1s[j] <= a[j];
        a2s[j] <= a1s[j];
        lo[j]  <= a2s[j] * $signed({1'b0, c2[3*j][31:0]});
        hi[j]  <= a2s[j] * $signed(c2[3*j][64:32]);
        t[j]   <= (98'(hi[j]) <<< 32) + 98'(lo[j]);
      end
      det <= t[0] + t[1] + t[2];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      q_data.cof[i] = c5[i];
    end
    q_data.det = det;
  end

endmodule

// ===== hw/rtl/mi3_queue.sv =====
// ----------------------------------------------------------------------------
// mi3_queue: short queue between front and back
// Register-based FIFO of determinant and cofactor entries.
// ----------------------------------------------------------------------------
module mi3_queue import mi3_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  mi3_entry_t push_data,
  output logic       push_ready,
  output logic       pop_valid,
  output mi3_entry_t pop_data,
  input  logic       pop
);

  mi3_entry_t      mem [Q_DEPTH];
  logic [Q_AW-1:0] wptr, rptr;
  logic [Q_AW:0]   count;
  logic            push, do_pop;

  assign push_ready = (count != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rptr];
  assign push       = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      count <= count + (Q_AW+1)'(push) - (Q_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count over depth");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (wptr - rptr) == count[Q_AW-1:0]) else $error("queue pointers out of step");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !push && count == (Q_AW+1)'(1)) |=> !pop_valid)
    else $error("queue not empty after last pop");

endmodule

// ===== hw/rtl/mi3_back.sv =====
// ----------------------------------------------------------------------------
// mi3_back: classification, division and saturation pipeline
// Magnitudes, threshold test, 32 restoring divide stages, output register.
// ----------------------------------------------------------------------------
module mi3_back import mi3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [THR_W-1:0] thr,
  input  logic             q_valid,
  input  mi3_entry_t       q_data,
  output logic             q_pop,
  mi3_out_if.source        result
);

  logic        badv;
  logic        v1;
  logic [32:0] vd;
  logic        vo;

  // stage 1: magnitudes and signs
  logic [63:0] cmag1 [9];
  logic [8:0]  cneg1;
  logic [97:0] dmag1;
  logic        dneg1;

  // divide stages, index 0 loaded by the prep stage
  logic [98:0] rr   [33][9];
  logic [31:0] nb   [33][9];
  logic [31:0] qq   [33][9];
  logic [8:0]  ovf  [33];
  logic [8:0]  sgn  [33];
  logic [98:0] dd   [33];
  logic        sing [33];
  logic [31:0] detq [33];

  logic [97:0] num  [9];
  logic [98:0] rs   [32][9];
  logic        ge   [32][9];

  logic [31:0] ro   [9];
  logic [31:0] deto;
  logic        so;

  assign badv  = !vo || result.ready;
  assign q_pop = badv && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      vd <= '0;
      vo <= 1'b0;
    end else if (badv) begin
      v1 <= q_valid;
      vd <= {vd[31:0], v1};
      vo <= vd[32];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      num[i] = 98'({cmag1[i], 33'b0}) + dmag1;
    end
    for (int k = 0; k < 32; k++) begin
      for (int i = 0; i < 9; i++) begin
        rs[k][i] = {rr[k][i][97:0], nb[k][i][5'(31-k)]};
        ge[k][i] = (rs[k][i] >= dd[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (badv) begin
      for (int i = 0; i < 9; i++) begin
        cneg1[i] <= q_data.cof[i][64];
        cmag1[i] <= q_data.cof[i][64] ? 64'(~q_data.cof[i] + 65'd1)
                                      : q_data.cof[i][63:0];
      end
      dneg1 <= q_data.det[97];
      dmag1 <= q_data.det[97] ? ~q_data.det + 98'd1 : q_data.det;

      // prep: rounded quotient (2|c|*2^32 + d) / 2d, top bits seed the remainder
      for (int i = 0; i < 9; i++) begin
        rr[0][i]  <= 99'(num[i][97:32]);
        nb[0][i]  <= num[i][31:0];
        qq[0][i]  <= '0;
        ovf[0][i] <= (99'(num[i][97:32]) >= {dmag1, 1'b0});
        sgn[0][i] <= cneg1[i] ^ dneg1;
      end
      dd[0]   <= {dmag1, 1'b0};
      sing[0] <= (dmag1 == '0) || (dmag1 < 98'(thr));
      detq[0] <= sat32(66'((dmag1 + 98'h8000_0000) >> 32), dneg1);

      for (int k = 0; k < 32; k++) begin
        for (int i = 0; i < 9; i++) begin
          rr[k+1][i] <= ge[k][i] ? rs[k][i] - dd[k] : rs[k][i];
          qq[k+1][i] <= {qq[k][i][30:0], ge[k][i]};
          nb[k+1][i] <= nb[k][i];
        end
        ovf[k+1]  <= ovf[k];
        sgn[k+1]  <= sgn[k];
        dd[k+1]   <= dd[k];
        sing[k+1] <= sing[k];
        detq[k+1] <= detq[k];
      end

      for (int i = 0; i < 9; i++) begin
        if (sing[32]) ro[i] <= (i % 4 == 0) ? Q_ONE : 32'd0;
        else ro[i] <= sat32({33'b0, ovf[32][i], qq[32][i]}, sgn[32][i]);
      end
      deto <= detq[32];
      so   <= sing[32];
    end
  end

  assign result.valid    = vo;
  assign result.r00      = ro[0];
  assign result.r01      = ro[1];
  assign result.r02      = ro[2];
  assign result.r10      = ro[3];
  assign result.r11      = ro[4];
  assign result.r12      = ro[5];
  assign result.r20      = ro[6];
  assign result.r21      = ro[7];
  assign result.r22      = ro[8];
  assign result.det_out  = deto;
  assign result.singular = so;

endmodule

// ===== hw/rtl/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: 3x3 inverse by the adjugate, signed Q16.16
// Front computes exact cofactors and determinant, a short queue decouples
// it from the back, which classifies, divides, rounds and saturates.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents
//  ---------+-----+-------------------------------------------------
//  matrix   | in  | a00..a22, signed Q16.16
//  result   | out | r00..r22, det_out (Q16.16, saturated), singular
//  cfg      | in  | cfg_we / cfg_data: singular_threshold, 56 bits
//
//  One matrix per cycle while results are taken. The path: five front
//  stages, the queue, then 35 back stages, of which 32 are one
//  restoring quotient bit each for all nine elements in parallel.
//  Synchronous active-high reset empties the pipelines and the queue and
//  loads the threshold with its default. A stalled result holds in the
//  output register; the back then holds, the queue fills, and the front
//  holds and drops ready once the queue is full.
//
module matrix_inverse_3x3 import mi3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_data,
  mi3_in_if.sink           matrix,
  mi3_out_if.source        result
);

  logic [THR_W-1:0] thr;
  logic             f_valid, f_ready;
  mi3_entry_t       f_data;
  logic             b_valid, b_pop;
  mi3_entry_t       b_data;

  // threshold register; the user must write it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  // front: products, cofactors, determinant
  mi3_front u_front (
    .clk     (clk),
    .rst     (rst),
    .matrix  (matrix),
    .q_valid (f_valid),
    .q_data  (f_data),
    .q_ready (f_ready)
  );

  // decoupling queue
  mi3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_data  (f_data),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_data   (b_data),
    .pop        (b_pop)
  );

  // back: threshold test, divide, saturate, output register
  mi3_back u_back (
    .clk     (clk),
    .rst     (rst),
    .thr     (thr),
    .q_valid (b_valid),
    .q_data  (b_data),
    .q_pop   (b_pop),
    .result  (result)
  );

  // singular beats carry the identity
  a_identity: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.singular) |->
      (result.r00 == Q_ONE && result.r11 == Q_ONE && result.r22 == Q_ONE &&
       result.r01 == 0 && result.r12 == 0 && result.r20 == 0))
    else $error("singular beat without identity");
  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=>
      (result.valid && $stable(result.det_out) && $stable(result.singular)))
    else $error("result beat changed while stalled");
  // front holds its entry while the queue is full
  a_push: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !f_ready) |=> f_valid)
    else $error("front lost an entry while the queue was full");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for matrix_inverse_3x3
// Drives random and directed 3x3 Q16.16 matrices with random gaps and
// backpressure, predicts the inverse, determinant and singular flag with
// exact wide arithmetic, and checks every result beat in order. The
// singular threshold is reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import mi3_pkg::*;

  typedef struct {
    logic [31:0] r [9];
    logic [31:0] det;
    logic        singular;
  } inv_result_t;

  // Expected-result store plus checker.
  class inverse_scoreboard;
    inv_result_t pending[$];
    int          errors;
    int          n_checked;
    int          n_singular;

    function void note_matrix(inv_result_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check_result(inv_result_t got);
      inv_result_t exp_res;
      if (pending.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      n_checked++;
      if (exp_res.singular) n_singular++;
      for (int i = 0; i < 9; i++) begin
        if (got.r[i] !== exp_res.r[i]) begin
          $display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                   exp_res.r[i], got.r[i]);
          errors++;
        end
      end
      if (got.det !== exp_res.det) begin
        $display("%0t: det_out expected %h actual %h", $time, exp_res.det, got.det);
        errors++;
      end
      if (got.singular !== exp_res.singular) begin
        $display("%0t: singular expected %b actual %b", $time, exp_res.singular,
                 got.singular);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [THR_W-1:0] cfg_data;

  mi3_in_if  matrix_ch();
  mi3_out_if result_ch();

  matrix_inverse_3x3 i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .matrix   (matrix_ch.sink),
    .result   (result_ch.source)
  );

  inverse_scoreboard sb;
  logic [THR_W-1:0]  threshold;   // predictor's copy of the register
  bit                long_hold;   // receiver holds off while set
  int                idle_cycles; // cycles with no beat on either side
  int                n_sent;

  localparam int LATENCY   = 50;
  localparam int WDOG_MAX  = 4000;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Round mag / dv to nearest, ties away, dv > 0, saturated to signed 32 bits.
  function automatic logic [31:0] round_sat(logic [255:0] mag, logic [255:0] dv,
                                            logic neg);
    logic [255:0] q;
    q = ((mag << 1) + dv) / (dv << 1);
    if (neg) begin
      if (q > 256'h8000_0000) return 32'h8000_0000;
      return 32'(-q);
    end
    if (q > 256'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic inv_result_t predict_inverse(logic signed [31:0] a [9]);
    logic signed [127:0] c [9];
    logic signed [127:0] det;
    logic [255:0]        dmag;
    logic [255:0]        cmag;
    inv_result_t         res;
    c[0] = 128'(a[4]) * a[8] - 128'(a[5]) * a[7];
    c[1] = 128'(a[2]) * a[7] - 128'(a[1]) * a[8];
    c[2] = 128'(a[1]) * a[5] - 128'(a[2]) * a[4];
    c[3] = 128'(a[5]) * a[6] - 128'(a[3]) * a[8];
    c[4] = 128'(a[0]) * a[8] - 128'(a[2]) * a[6];
    c[5] = 128'(a[2]) * a[3] - 128'(a[0]) * a[5];
    c[6] = 128'(a[3]) * a[7] - 128'(a[4]) * a[6];
    c[7] = 128'(a[1]) * a[6] - 128'(a[0]) * a[7];
    c[8] = 128'(a[0]) * a[4] - 128'(a[1]) * a[3];
    det = 128'(a[0]) * c[0] + 128'(a[1]) * c[3] + 128'(a[2]) * c[6];
    dmag = 256'(det < 0 ? -det : det);
    // determinant: Q48.48 to Q16.16, round half away
    begin
      logic [255:0] m;
      m = (dmag + 256'h8000_0000) >> 32;
      if (det < 0) res.det = (m > 256'h8000_0000) ? 32'h8000_0000 : 32'(-m);
      else res.det = (m > 256'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    if (dmag == 0 || dmag < 256'(threshold)) begin
      for (int i = 0; i < 9; i++) res.r[i] = (i % 4 == 0) ? Q_ONE : 32'h0;
      res.singular = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++) begin
        cmag = 256'(c[i] < 0 ? -c[i] : c[i]);
        res.r[i] = round_sat(cmag << 32, dmag, (c[i] < 0) != (det < 0));
      end
      res.singular = 1'b0;
    end
    return res;
  endfunction

  // Hold valid for one beat, with a random gap before it.
  task automatic send_matrix(logic signed [31:0] a [9], bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      matrix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    matrix_ch.valid <= 1'b1;
    matrix_ch.a00 <= a[0]; matrix_ch.a01 <= a[1]; matrix_ch.a02 <= a[2];
    matrix_ch.a10 <= a[3]; matrix_ch.a11 <= a[4]; matrix_ch.a12 <= a[5];
    matrix_ch.a20 <= a[6]; matrix_ch.a21 <= a[7]; matrix_ch.a22 <= a[8];
    do @(posedge clk); while (!matrix_ch.ready);
    sb.note_matrix(predict_inverse(a));
    n_sent++;
  endtask

  task automatic release_input();
    matrix_ch.valid <= 1'b0;
  endtask

  // Wait until every expected beat is back, then let the pipe drain.
  task automatic drain();
    release_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    threshold = val;
  endtask

  function automatic logic signed [31:0] rand_elem(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      2: return $signed($urandom_range(0, 32'h60_0000)) - 32'sh30_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0001_0000;
          3: return -32'sh0001_0000;
          4: return 32'sh0;
          default: return $signed($urandom_range(0, 15)) - 8;
        endcase
      end
    endcase
  endfunction

  // Random matrix; some rows are made dependent to hit singular cases.
  task automatic random_matrix(output logic signed [31:0] a [9]);
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      a[i] = rand_elem(mode < 2 ? 0 : mode < 6 ? 1 : mode < 8 ? 2 : 3);
    if ($urandom_range(0, 9) == 0)
      for (int i = 0; i < 3; i++) a[6 + i] = a[i];
  endtask

  // Receiver: random ready, plus a long hold when asked.
  initial begin
    inv_result_t got;
    int          wait_n;
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
      end else begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (wait_n > 0) begin
          result_ch.ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
        result_ch.ready <= 1'b1;
        do @(posedge clk); while (!result_ch.valid);
        got.r[0] = result_ch.r00; got.r[1] = result_ch.r01; got.r[2] = result_ch.r02;
        got.r[3] = result_ch.r10; got.r[4] = result_ch.r11; got.r[5] = result_ch.r12;
        got.r[6] = result_ch.r20; got.r[7] = result_ch.r21; got.r[8] = result_ch.r22;
        got.det = result_ch.det_out;
        got.singular = result_ch.singular;
        sb.check_result(got);
      end
    end
  end

  // Hold-off for the long stall, counted here so the sender keeps offering.
  task automatic hold_receiver(int cycles);
    long_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    long_hold = 1'b0;
  endtask

  // Watchdog: count cycles without any beat.
  always @(posedge clk) begin
    if (rst || (matrix_ch.valid && matrix_ch.ready) ||
        (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("%0t: watchdog expired", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  // Stray beat outside a pending result also counts, via the checker.
  initial begin
    logic signed [31:0]  m [9];
    logic [THR_W-1:0]    thr_set [5];
    sb = new();
    long_hold = 1'b0;
    idle_cycles = 0;
    n_sent = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    threshold = THR_RESET;
    matrix_ch.valid = 1'b0;
    {matrix_ch.a00, matrix_ch.a01, matrix_ch.a02} = '0;
    {matrix_ch.a10, matrix_ch.a11, matrix_ch.a12} = '0;
    {matrix_ch.a20, matrix_ch.a21, matrix_ch.a22} = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, zero, extremes, scaled and singular matrices.
    m = '{default: 0}; m[0] = Q_ONE; m[4] = Q_ONE; m[8] = Q_ONE;
    send_matrix(m);
    m = '{default: 0};
    send_matrix(m);                                 // zero determinant
    m = '{default: 32'sh7FFF_FFFF};
    send_matrix(m);                                 // dependent rows
    m = '{default: 0}; m[0] = 32'sh7FFF_FFFF; m[4] = 32'sh7FFF_FFFF;
    m[8] = 32'sh7FFF_FFFF;
    send_matrix(m);                                 // huge determinant
    m = '{default: 0}; m[0] = 32'sh8000_0000; m[4] = 32'sh8000_0000;
    m[8] = 32'sh8000_0000;
    send_matrix(m);                                 // most negative
    m = '{default: 0}; m[0] = 32'sh1; m[4] = 32'sh1; m[8] = 32'sh1;
    send_matrix(m);                                 // tiny, below default
    m = '{default: 0}; m[0] = 32'sh0000_0100; m[4] = 32'sh0000_0100;
    m[8] = 32'sh0000_0100;
    send_matrix(m);                                 // large inverse, not saturated
    m = '{default: 0}; m[1] = Q_ONE; m[3] = Q_ONE; m[8] = -32'sh1_0000;
    send_matrix(m);                                 // permutation
    m = '{32'sh2_0000, 32'sh1_0000, 0, 32'sh1_0000, 32'sh3_0000, 32'sh1_0000,
          0, 32'sh1_0000, 32'sh4_0000};
    send_matrix(m);
    m = '{32'sh3_0000, 0, 0, 0, 32'sh3_0000, 0, 0, 0, 32'sh3_0000};
    send_matrix(m);                                 // inverse of one third, rounded
    m = '{default: 32'shFFFF_FFFF};
    send_matrix(m);
    m = '{-32'sh1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh5555_5555,
          32'shAAAA_AAAA, 32'sh1, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh1234_5678};
    send_matrix(m);
    drain();

    // Threshold sweep: zero, default-ish, mid, max, and mixed.
    thr_set = '{56'd0, THR_RESET, 56'h1_0000_0000_0000, {THR_W{1'b1}},
                56'h0000_00AB_CDEF_0123};
    for (int p = 0; p < 5; p++) begin
      write_threshold(thr_set[p]);
      // zero-determinant case at this setting
      m = '{default: 0}; send_matrix(m);
      for (int k = 0; k < 360; k++) begin
        random_matrix(m);
        send_matrix(m, $urandom_range(0, 3) == 0);
        if (p == 1 && k == 100) fork hold_receiver(300); join_none
      end
      if (p == 2) begin
        // pause the sender until every result is back
        drain();
      end
      drain();
    end

    // Threshold back to default for a final random burst.
    write_threshold(THR_RESET);
    for (int k = 0; k < 60; k++) begin
      random_matrix(m);
      send_matrix(m);
    end
    drain();

    $display("Sent %0d matrices, checked %0d results (%0d singular) over six",
             n_sent, sb.n_checked, sb.n_singular);
    $display("threshold settings including zero and full scale");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
